// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffha_pkg
// Shared types and defaults for the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ALIGN_BYTES_DEF  = 4;
    localparam int MIN_PAYLOAD_DEF  = 12;

    localparam int SIZE_W    = 13;
    localparam int ADDR_W    = 13;
    localparam int PAYLOAD_W = 12;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic {
        STAT_OK   = 1'b0,
        STAT_FAIL = 1'b1
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [PAYLOAD_W-1:0] payload_address;
    } t_out_word;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_DIV,
        S_A_SZ,
        S_A_LOOP,
        S_A_CHK,
        S_A_SPWR,
        S_A_HWR,
        S_ADV,
        S_ADV_CHK,
        S_F_RD,
        S_F_CHK,
        S_F_NRD,
        S_F_NCHK,
        S_F_P,
        S_F_PCHK,
        S_F_TWR,
        S_PFX_RD,
        S_PFX_WR,
        S_DONE
    } t_state;

    // Position of the lowest set bit of a small positive constant.
    function automatic int low_bit(input int v);
        int i;
        low_bit = 0;
        for (i = 15; i >= 0; i--) begin
            if (v[i]) begin
                low_bit = i;
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ffha_hdr_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffha_hdr_mem
// Block header store: one write port and one registered read port.
// ============================================================================
module ffha_hdr_mem #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10,
    parameter int DW    = 28
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator with block splitting and neighbor coalescing.
// ============================================================================
// One request word enters on the input channel (allocate or free) and exactly
// one result word leaves on the output channel, both with valid/ready.
// The block headers live in a single-port-read, single-port-write memory with
// one entry per header granule; each visited header is read and then checked
// from the registered read data. Allocate rounds the size, rejects a zero or
// oversized request, walks the headers from the lowest-free pointer, splits
// the block when enough is left, and advances the lowest-free pointer when it
// pointed at the taken block. Free checks the address and the header, then
// merges a free next and a free previous neighbor. The walk length sets the
// allocate rate; the engine returns to idle between requests.
// One request is worked on at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is still stalled.
// After reset the header memory is swept once, one entry per cycle, and no
// request is taken until the sweep ends. A stalled receiver holds the result
// word and, after the next request is done, holds the engine as well.
// ============================================================================
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
    parameter int MIN_PAYLOAD  = ffha_pkg::MIN_PAYLOAD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ffha_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ffha_pkg::t_out_word     o_out_word
);

    localparam int OW    = $clog2(HEAP_BYTES + 1);
    localparam int CW    = ((OW > 14) ? OW : 14) + 3;
    localparam int GA    = ffha_pkg::low_bit(ALIGN_BYTES);
    localparam int GH    = ffha_pkg::low_bit(HEADER_BYTES);
    localparam int GSH   = (GA < GH) ? GA : GH;
    localparam int GRAN  = 1 << GSH;
    localparam int DEPTH = (HEAP_BYTES + GRAN - 1) / GRAN;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = 14;
    localparam int SH    = XW + 6;
    localparam int RW    = SH + 1;
    localparam int RECIP = ((1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int MINSZ = ((MIN_PAYLOAD + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int DW    = 2 * OW + 2;

    localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] MIN_C   = CW'(MINSZ);
    localparam logic [CW-1:0] GMASK_C = CW'(GRAN - 1);

    typedef struct packed {
        logic          valid;
        logic          used;
        logic [OW-1:0] prev;
        logic [OW-1:0] next;
    } t_hdr;

    function automatic logic [IW-1:0] idx(input logic [CW-1:0] off);
        idx = IW'(off >> GSH);
    endfunction

    ffha_pkg::t_state    r_state, n_state;
    logic [IW-1:0]       r_clr;
    logic [CW-1:0]       r_lowest;
    logic [CW-1:0]       r_ptr;
    logic [CW-1:0]       r_aux;
    logic [CW-1:0]       r_cur;
    logic [CW-1:0]       r_sz;
    logic [CW-1:0]       r_fix_addr;
    logic [CW-1:0]       r_fix_prev;
    logic                r_fix;
    ffha_pkg::t_state    r_ret;
    t_hdr                r_hdr;
    logic [XW-1:0]       r_x;
    logic [XW-1:0]       r_q;
    logic                r_req_zero;
    ffha_pkg::t_status   r_status;
    logic [CW-1:0]       r_res_addr;
    logic                r_out_valid;
    ffha_pkg::t_out_word r_out;

    logic          w_wr_en, w_rd_en;
    logic [IW-1:0] w_wr_addr, w_rd_addr;
    t_hdr          w_wr_data;
    logic [DW-1:0] w_rd_raw;
    t_hdr          d;
    logic [CW-1:0] d_next;

    logic             w_in_acc, w_out_free;
    logic [CW-1:0]    w_free_addr;
    logic             w_free_bad;
    logic [XW+RW-1:0] w_prod;
    logic [CW-1:0]    w_sz_raw, w_sz;
    logic             w_loop_ok, w_fit, w_split;
    logic [CW-1:0]    w_p2;
    logic             w_n_ok, w_p_ok;

    ffha_hdr_mem #(
        .DEPTH(DEPTH),
        .IW   (IW),
        .DW   (DW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_raw)
    );

    assign d      = t_hdr'(w_rd_raw);
    assign d_next = CW'(d.next);

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_free_addr = CW'(i_in_word.block_address);
    assign w_free_bad  = (w_free_addr < HDR_C) || (w_free_addr > HEAP_C) ||
                         (((w_free_addr - HDR_C) & GMASK_C) != '0);

    // Rounding to the alignment: multiply by the reciprocal, then scale back.
    assign w_prod   = (XW+RW)'(r_x) * (XW+RW)'(RECIP);
    assign w_sz_raw = CW'(CW'(r_q) * CW'(ALIGN_BYTES));
    assign w_sz     = (w_sz_raw < MIN_C) ? MIN_C : w_sz_raw;

    assign w_loop_ok = (r_ptr < HEAP_C) && ((r_ptr + r_sz) < HEAP_C);
    assign w_p2      = r_ptr + HDR_C + r_sz;
    assign w_fit     = !d.used && (d_next >= w_p2);
    assign w_split   = d_next >= (w_p2 + HDR_C + MIN_C);
    assign w_n_ok    = (d_next < HEAP_C) && (d_next != r_ptr);
    assign w_p_ok    = (CW'(r_hdr.prev) != r_ptr) && (CW'(r_hdr.prev) < HEAP_C);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_CLEAR: begin
                if (r_clr == IW'(DEPTH - 1)) n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_word.operation == ffha_pkg::OP_ALLOC) begin
                        n_state = ffha_pkg::S_A_DIV;
                    end else if (w_free_bad) begin
                        n_state = ffha_pkg::S_DONE;
                    end else begin
                        n_state = ffha_pkg::S_F_RD;
                    end
                end
            end
            ffha_pkg::S_A_DIV: n_state = ffha_pkg::S_A_SZ;
            ffha_pkg::S_A_SZ: begin
                if (r_req_zero || w_sz > HEAP_C) n_state = ffha_pkg::S_DONE;
                else n_state = ffha_pkg::S_A_LOOP;
            end
            ffha_pkg::S_A_LOOP: begin
                n_state = w_loop_ok ? ffha_pkg::S_A_CHK : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_A_CHK: begin
                if (w_fit) begin
                    n_state = w_split ? ffha_pkg::S_A_SPWR : ffha_pkg::S_A_HWR;
                end else if (d_next <= r_ptr) begin
                    n_state = ffha_pkg::S_DONE;
                end else begin
                    n_state = ffha_pkg::S_A_LOOP;
                end
            end
            ffha_pkg::S_A_SPWR: begin
                n_state = (r_fix_addr < HEAP_C) ? ffha_pkg::S_PFX_RD : ffha_pkg::S_A_HWR;
            end
            ffha_pkg::S_A_HWR: begin
                n_state = (r_lowest == r_ptr) ? ffha_pkg::S_ADV : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_ADV: begin
                n_state = (r_cur < HEAP_C) ? ffha_pkg::S_ADV_CHK : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_ADV_CHK: begin
                n_state = d.used ? ffha_pkg::S_ADV : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_F_RD: n_state = ffha_pkg::S_F_CHK;
            ffha_pkg::S_F_CHK: begin
                if (!d.valid || !d.used) n_state = ffha_pkg::S_DONE;
                else if (w_n_ok) n_state = ffha_pkg::S_F_NRD;
                else n_state = ffha_pkg::S_F_P;
            end
            ffha_pkg::S_F_NRD: n_state = ffha_pkg::S_F_NCHK;
            ffha_pkg::S_F_NCHK: begin
                if (!d.used && d_next < HEAP_C) n_state = ffha_pkg::S_PFX_RD;
                else n_state = ffha_pkg::S_F_P;
            end
            ffha_pkg::S_F_P: begin
                n_state = w_p_ok ? ffha_pkg::S_F_PCHK : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_F_PCHK: n_state = ffha_pkg::S_F_TWR;
            ffha_pkg::S_F_TWR: begin
                n_state = r_fix ? ffha_pkg::S_PFX_RD : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_PFX_RD: n_state = ffha_pkg::S_PFX_WR;
            ffha_pkg::S_PFX_WR: n_state = r_ret;
            ffha_pkg::S_DONE: begin
                if (w_out_free) n_state = ffha_pkg::S_IDLE;
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // Memory port controls and input ready.
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = '0;
        w_wr_data  = '0;
        unique case (r_state)
            ffha_pkg::S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                if (r_clr == '0) begin
                    w_wr_data = '{valid: 1'b1, used: 1'b0, prev: '0, next: OW'(HEAP_BYTES)};
                end
            end
            ffha_pkg::S_IDLE: o_in_ready = 1'b1;
            ffha_pkg::S_A_LOOP: begin
                w_rd_en   = w_loop_ok;
                w_rd_addr = idx(r_ptr);
            end
            ffha_pkg::S_A_SPWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = idx(r_aux);
                w_wr_data = '{valid: 1'b1, used: 1'b0, prev: OW'(r_ptr),
                              next: OW'(r_fix_addr)};
            end
            ffha_pkg::S_A_HWR, ffha_pkg::S_F_TWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = idx(r_ptr);
                w_wr_data = r_hdr;
            end
            ffha_pkg::S_ADV: begin
                w_rd_en   = r_cur < HEAP_C;
                w_rd_addr = idx(r_cur);
            end
            ffha_pkg::S_F_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = idx(r_ptr);
            end
            ffha_pkg::S_F_NRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = idx(r_aux);
            end
            ffha_pkg::S_F_NCHK: begin
                // If the next block is free it is absorbed: its header goes dead.
                w_wr_en   = !d.used;
                w_wr_addr = idx(r_aux);
                w_wr_data = '{valid: 1'b0, used: d.used, prev: d.prev, next: d.next};
            end
            ffha_pkg::S_F_P: begin
                if (w_p_ok) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = idx(CW'(r_hdr.prev));
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = idx(r_ptr);
                    w_wr_data = r_hdr;
                end
            end
            ffha_pkg::S_F_PCHK: begin
                w_wr_en   = !d.used;
                w_wr_addr = idx(r_aux);
                w_wr_data = '{valid: d.valid, used: d.used, prev: d.prev, next: r_hdr.next};
            end
            ffha_pkg::S_PFX_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = idx(r_fix_addr);
            end
            ffha_pkg::S_PFX_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = idx(r_fix_addr);
                w_wr_data = '{valid: d.valid, used: d.used, prev: OW'(r_fix_prev),
                              next: d.next};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffha_pkg::S_CLEAR;
            r_clr       <= '0;
            r_lowest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ffha_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ffha_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ffha_pkg::S_ADV: begin
                    if (r_cur >= HEAP_C) r_lowest <= r_cur;
                end
                ffha_pkg::S_ADV_CHK: begin
                    if (!d.used) r_lowest <= r_cur;
                end
                ffha_pkg::S_F_CHK: begin
                    if (d.valid && d.used && r_ptr < r_lowest) r_lowest <= r_ptr;
                end
                ffha_pkg::S_F_NCHK: begin
                    if (!d.used && r_lowest == r_aux) r_lowest <= r_ptr;
                end
                ffha_pkg::S_F_PCHK: begin
                    if (!d.used && r_lowest == r_ptr) r_lowest <= r_aux;
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_status   <= ffha_pkg::STAT_FAIL;
                    r_res_addr <= '0;
                    r_x        <= XW'(i_in_word.request_size) + XW'(ALIGN_BYTES - 1);
                    r_req_zero <= i_in_word.request_size == '0;
                    r_ptr      <= w_free_addr - HDR_C;
                end
            end
            ffha_pkg::S_A_DIV: r_q <= XW'(w_prod >> SH);
            ffha_pkg::S_A_SZ: begin
                r_sz  <= w_sz;
                r_ptr <= r_lowest;
            end
            ffha_pkg::S_A_CHK: begin
                if (w_fit) begin
                    r_hdr      <= '{valid: d.valid, used: 1'b1, prev: d.prev,
                                    next: w_split ? OW'(w_p2) : d.next};
                    r_aux      <= w_p2;
                    r_fix_addr <= d_next;
                    r_fix_prev <= w_p2;
                    r_ret      <= ffha_pkg::S_A_HWR;
                    r_res_addr <= r_ptr + HDR_C;
                    r_status   <= ffha_pkg::STAT_OK;
                end else begin
                    r_ptr <= d_next;
                end
            end
            ffha_pkg::S_A_HWR: begin
                r_cur <= (CW'(r_hdr.next) <= r_ptr) ? HEAP_C : CW'(r_hdr.next);
            end
            ffha_pkg::S_ADV_CHK: begin
                if (d.used) r_cur <= (d_next <= r_cur) ? HEAP_C : d_next;
            end
            ffha_pkg::S_F_CHK: begin
                if (d.valid && d.used) begin
                    r_hdr    <= '{valid: d.valid, used: 1'b0, prev: d.prev, next: d.next};
                    r_status <= ffha_pkg::STAT_OK;
                end
                r_aux <= d_next;
            end
            ffha_pkg::S_F_NCHK: begin
                if (!d.used) begin
                    r_hdr.next <= d.next;
                    r_fix_addr <= d_next;
                    r_fix_prev <= r_ptr;
                end
                r_ret <= ffha_pkg::S_F_P;
            end
            ffha_pkg::S_F_P: r_aux <= CW'(r_hdr.prev);
            ffha_pkg::S_F_PCHK: begin
                if (!d.used) begin
                    r_hdr.valid <= 1'b0;
                    r_fix       <= CW'(r_hdr.next) < HEAP_C;
                    r_fix_addr  <= CW'(r_hdr.next);
                    r_fix_prev  <= r_aux;
                end else begin
                    r_fix <= 1'b0;
                end
                r_ret <= ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out.status          <= r_status;
                    r_out.payload_address <= ffha_pkg::PAYLOAD_W'(r_res_addr);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_lowest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lowest <= HEAP_C)
        else $error("lowest free offset beyond heap");

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en))
        else $error("header read and write in the same cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ffha_pkg::S_IDLE))
        else $error("request accepted but engine stayed idle");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ffha_pkg::STAT_FAIL) |->
        (o_out_word.payload_address == '0))
        else $error("failed result carries an address");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the first-fit heap allocator against a behavioral heap model: directed
// corner requests, then random allocate/free traffic under several idle and stall settings.
// ============================================================================
module testbench;

    localparam int HEAP   = 4096;
    localparam int HDR    = 8;
    localparam int ALIGN  = 4;
    localparam int MINPAY = 12;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    ffha_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    ffha_pkg::t_out_word o_out_word;

    first_fit_heap_allocator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // Heap model state.
    int unsigned hdr_next [HEAP];
    int unsigned hdr_prev [HEAP];
    bit          hdr_used [HEAP];
    bit          hdr_live [HEAP];
    int unsigned lowest_free;

    ffha_pkg::t_out_word pending_results[$];
    int unsigned         live_addrs[$];
    int                  error_count;
    int                  send_idle_pct;
    int                  stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned align_up(int unsigned s);
        return ((s + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    task automatic heap_reset();
        for (int i = 0; i < HEAP; i++) begin
            hdr_next[i] = '0;
            hdr_prev[i] = '0;
            hdr_used[i] = 1'b0;
            hdr_live[i] = 1'b0;
        end
        hdr_next[0] = HEAP;
        hdr_live[0] = 1'b1;
        lowest_free = '0;
    endtask

    task automatic advance_lowest(int unsigned from);
        int unsigned cur;
        int unsigned nx;
        cur = from;
        while (cur < HEAP && hdr_used[cur]) begin
            nx = hdr_next[cur];
            if (nx <= cur) begin
                cur = HEAP;
                break;
            end
            cur = nx;
        end
        lowest_free = cur;
    endtask

    task automatic alloc_model(int unsigned req, output bit ok, output int unsigned addr);
        int unsigned minsz;
        int unsigned sz;
        int unsigned ptr;
        int unsigned nx;
        int unsigned p2;
        ok = 0;
        addr = 0;
        minsz = align_up(MINPAY);
        if (req == 0) return;
        sz = align_up(req);
        if (sz < minsz) sz = minsz;
        if (sz > HEAP) return;
        ptr = lowest_free;
        while (ptr < HEAP && ptr + sz < HEAP) begin
            nx = hdr_next[ptr];
            if (!hdr_used[ptr] && nx >= ptr + HDR + sz) begin
                if (nx >= ptr + HDR + sz + HDR + minsz) begin
                    p2 = ptr + HDR + sz;
                    hdr_next[p2] = nx;
                    hdr_prev[p2] = ptr;
                    hdr_used[p2] = 1'b0;
                    hdr_live[p2] = 1'b1;
                    if (nx < HEAP) hdr_prev[nx] = p2;
                    hdr_next[ptr] = p2;
                end
                hdr_used[ptr] = 1'b1;
                if (lowest_free == ptr) advance_lowest(ptr);
                addr = ptr + HDR;
                ok = 1;
                return;
            end
            if (nx <= ptr) break;
            ptr = nx;
        end
    endtask

    function automatic bit free_model(int unsigned addr);
        int unsigned t;
        int unsigned n;
        int unsigned p;
        int unsigned nn;
        if (addr < HDR || addr > HEAP) return 0;
        t = addr - HDR;
        if (t >= HEAP) return 0;
        if (!hdr_live[t] || !hdr_used[t]) return 0;
        hdr_used[t] = 1'b0;
        if (t < lowest_free) lowest_free = t;
        n = hdr_next[t];
        if (n < HEAP && n != t && !hdr_used[n]) begin
            if (lowest_free == n) lowest_free = t;
            nn = hdr_next[n];
            hdr_next[t] = nn;
            hdr_live[n] = 1'b0;
            if (nn < HEAP) hdr_prev[nn] = t;
        end
        p = hdr_prev[t];
        if (p != t && p < HEAP && !hdr_used[p]) begin
            if (lowest_free == t) lowest_free = p;
            nn = hdr_next[t];
            hdr_next[p] = nn;
            hdr_live[t] = 1'b0;
            if (nn < HEAP) hdr_prev[nn] = p;
        end
        return 1;
    endfunction

    // Sends one word and records its expected result at acceptance. Valid is
    // left high after the accepting edge; the next word or an idle gap takes
    // over at the following falling edge.
    task automatic send_word(ffha_pkg::t_op op, int unsigned size, int unsigned baddr);
        ffha_pkg::t_out_word want;
        bit                  ok;
        int unsigned         addr;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_word.operation     <= op;
        i_in_word.request_size  <= size[12:0];
        i_in_word.block_address <= baddr[12:0];
        i_in_valid              <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == ffha_pkg::OP_ALLOC) begin
            alloc_model(size, ok, addr);
            if (ok) live_addrs.push_back(addr);
        end else begin
            ok = free_model(baddr);
            addr = 0;
            if (ok) begin
                foreach (live_addrs[i])
                    if (live_addrs[i] == baddr) begin
                        live_addrs.delete(i);
                        break;
                    end
            end
        end
        want.status          = ok ? ffha_pkg::STAT_OK : ffha_pkg::STAT_FAIL;
        want.payload_address = addr[11:0];
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_pct > 0)
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        else
            i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        ffha_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           o_out_word.status);
                    error_count++;
                end
                if (o_out_word.payload_address !== want.payload_address) begin
                    $error("payload_address: expected %0d, got %0d",
                           want.payload_address, o_out_word.payload_address);
                    error_count++;
                end
            end
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_word(ffha_pkg::OP_ALLOC, 0, 0);
        send_word(ffha_pkg::OP_ALLOC, 4096, 0);
        send_word(ffha_pkg::OP_ALLOC, 8191, 8191);
        send_word(ffha_pkg::OP_ALLOC, 4089, 0);
        send_word(ffha_pkg::OP_FREE, 0, 0);
        send_word(ffha_pkg::OP_FREE, 0, 7);
        send_word(ffha_pkg::OP_FREE, 0, 4104);
        send_word(ffha_pkg::OP_FREE, 8191, 8191);
        send_word(ffha_pkg::OP_ALLOC, 1, 0);
        send_word(ffha_pkg::OP_ALLOC, 13, 0);
        send_word(ffha_pkg::OP_ALLOC, 100, 0);
        send_word(ffha_pkg::OP_FREE, 0, 30);
        send_word(ffha_pkg::OP_FREE, 0, 28);
        send_word(ffha_pkg::OP_FREE, 0, 28);
        send_word(ffha_pkg::OP_FREE, 0, 8);
        send_word(ffha_pkg::OP_FREE, 0, 4096);
        send_word(ffha_pkg::OP_ALLOC, 4000, 0);
        send_word(ffha_pkg::OP_ALLOC, 4000, 0);
        send_word(ffha_pkg::OP_FREE, 0, 8);
        send_word(ffha_pkg::OP_FREE, 0, 48);
        send_word(ffha_pkg::OP_ALLOC, 4080, 0);
        send_word(ffha_pkg::OP_FREE, 0, 8);
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall);
        int unsigned pick;
        int unsigned size;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Mostly small sizes so the chain grows long; a few large ones.
                size = ($urandom_range(9) == 0) ? $urandom_range(4096) :
                       $urandom_range(1, 160);
                send_word(ffha_pkg::OP_ALLOC, size, $urandom);
            end else if (pick < 85 && live_addrs.size() != 0) begin
                send_word(ffha_pkg::OP_FREE, $urandom,
                          live_addrs[$urandom_range(live_addrs.size() - 1)]);
            end else if (pick < 93) begin
                send_word(ffha_pkg::OP_FREE, $urandom, $urandom_range(8191));
            end else begin
                send_word(ffha_pkg::OP_ALLOC, $urandom_range(8191), $urandom);
            end
        end
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        i_out_ready   = 1'b1;
        heap_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(410, 0, 0);
        test_random(410, 59, 0);
        test_random(410, 0, 59);
        test_random(398, 28, 28);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
